>>> design/csf_pkg.sv
package csf_pkg;

    // Fixed field widths
    localparam int COUNT_W = 9;
    localparam int TID_W   = 3;
    localparam int INIT_W  = 8;

    // Count limit for a post, and the count loaded at reset
    localparam logic signed [COUNT_W-1:0] COUNT_MAX  = 9'sd255;
    localparam logic [INIT_W-1:0]         INIT_RESET = 8'd1;

    // Default depth of the wait queue
    localparam int DEF_MAX_WAITERS = 8;

    // Operation codes
    localparam logic OP_WAIT = 1'b0;
    localparam logic OP_POST = 1'b1;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_EXEC = 2'b10
    } t_state;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;   // latch the incoming request
        logic commit;    // update state and load the result register
        logic load_cfg;  // reload count, empty the queue
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic out_stall; // result register full and not being taken
    } t_status;

endpackage

>>> design/csf_ram.sv
module csf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Single write port, registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/csf_ctrl.sv
module csf_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic              i_cfg_valid,
    input  csf_pkg::t_status  i_status,
    output logic              o_ready,
    output logic              o_cfg_ready,
    output csf_pkg::t_cmd     o_cmd
);
    import csf_pkg::*;

    t_state r_state;
    t_state n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                if (!i_status.out_stall) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Handshakes and commands
    assign o_ready        = (r_state == S_IDLE);
    assign o_cfg_ready    = (r_state == S_IDLE);
    assign o_cmd.capture  = (r_state == S_IDLE) && i_valid;
    assign o_cmd.commit   = (r_state == S_EXEC) && !i_status.out_stall;
    assign o_cmd.load_cfg = (r_state == S_IDLE) && i_cfg_valid;

endmodule

>>> design/csf_dp.sv
module csf_dp #(
    parameter int MAX_WAITERS = csf_pkg::DEF_MAX_WAITERS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  csf_pkg::t_cmd                         i_cmd,
    output csf_pkg::t_status                      o_status,
    input  logic                                  i_op,
    input  logic [csf_pkg::TID_W-1:0]             i_task_id,
    input  logic [csf_pkg::INIT_W-1:0]            i_cfg_data,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic                                  o_blocked,
    output logic                                  o_wake_valid,
    output logic [csf_pkg::TID_W-1:0]             o_wake_task,
    output logic                                  o_refused,
    output logic signed [csf_pkg::COUNT_W-1:0]    o_count
);
    import csf_pkg::*;

    localparam int PTR_W = $clog2(MAX_WAITERS);
    localparam int CNT_W = $clog2(MAX_WAITERS + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(MAX_WAITERS - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(MAX_WAITERS);

    // Captured request
    logic                      r_op;
    logic [TID_W-1:0]          r_tid;

    // Semaphore state
    logic signed [COUNT_W-1:0] r_count;
    logic [PTR_W-1:0]          r_enq_pos;
    logic [PTR_W-1:0]          r_deq_pos;
    logic [CNT_W-1:0]          r_waiting;

    // Result register
    logic                      r_out_valid;
    logic                      r_blocked;
    logic                      r_wake_valid;
    logic [TID_W-1:0]          r_wake_task;
    logic                      r_refused;
    logic signed [COUNT_W-1:0] r_out_count;

    // Decision
    logic                      n_blocked;
    logic                      n_wake;
    logic                      n_refused;
    logic signed [COUNT_W-1:0] n_count;
    logic [TID_W-1:0]          ram_rdata;

    // Wait queue storage; read address follows the head pointer
    csf_ram #(
        .WIDTH (TID_W),
        .DEPTH (MAX_WAITERS)
    ) u_queue (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && n_blocked),
        .i_waddr (r_enq_pos),
        .i_wdata (r_tid),
        .i_raddr (r_deq_pos),
        .o_rdata (ram_rdata)
    );

    // Request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_op;
            r_tid <= i_task_id;
        end
    end

    // Operation decision
    always_comb begin
        n_blocked = 1'b0;
        n_wake    = 1'b0;
        n_refused = 1'b0;
        n_count   = r_count;
        case (r_op)
            OP_WAIT: begin
                // count at or below zero: caller has to queue, or is refused if the queue is full
                if (r_count[COUNT_W-1] || (r_count == '0)) begin
                    if (r_waiting == CNT_FULL) begin
                        n_refused = 1'b1;
                    end else begin
                        n_blocked = 1'b1;
                        n_count   = r_count - 9'sd1;
                    end
                end else begin
                    n_count = r_count - 9'sd1;
                end
            end
            default: begin
                if (r_count == COUNT_MAX) begin
                    n_refused = 1'b1;
                end else begin
                    n_count = r_count + 9'sd1;
                    // negative before the post: release the oldest waiter
                    n_wake  = r_count[COUNT_W-1] && (r_waiting != '0);
                end
            end
        endcase
    end

    // Semaphore state update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count   <= $signed({1'b0, INIT_RESET});
            r_enq_pos <= '0;
            r_deq_pos <= '0;
            r_waiting <= '0;
        end else if (i_cmd.load_cfg) begin
            r_count   <= $signed({1'b0, i_cfg_data});
            r_enq_pos <= '0;
            r_deq_pos <= '0;
            r_waiting <= '0;
        end else if (i_cmd.commit) begin
            r_count <= n_count;
            if (n_blocked) begin
                r_enq_pos <= (r_enq_pos == PTR_LAST) ? '0 : r_enq_pos + 1'b1;
                r_waiting <= r_waiting + 1'b1;
            end
            if (n_wake) begin
                r_deq_pos <= (r_deq_pos == PTR_LAST) ? '0 : r_deq_pos + 1'b1;
                r_waiting <= r_waiting - 1'b1;
            end
        end
    end

    // Result valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_blocked    <= n_blocked;
            r_wake_valid <= n_wake;
            r_wake_task  <= n_wake ? ram_rdata : '0;
            r_refused    <= n_refused;
            r_out_count  <= n_count;
        end
    end

    assign o_status.out_stall = r_out_valid && !i_ready;

    assign o_valid      = r_out_valid;
    assign o_blocked    = r_blocked;
    assign o_wake_valid = r_wake_valid;
    assign o_wake_task  = r_wake_task;
    assign o_refused    = r_refused;
    assign o_count      = r_out_count;

    // Queue fill never passes its depth
    a_waiting_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_waiting <= CNT_FULL)
        else $error("wait queue fill above depth");

    // Negative count equals the number of queued tasks
    a_neg_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count[COUNT_W-1] |-> (COUNT_W'(r_waiting) == COUNT_W'(-r_count)))
        else $error("count and queue fill disagree");

    // No waiters while the count is not negative
    a_pos_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_count[COUNT_W-1] |-> (r_waiting == '0))
        else $error("tasks queued with non-negative count");

    // A blocking wait grows the queue by one
    a_enqueue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.commit && n_blocked) |=> (r_waiting == $past(r_waiting) + 1'b1))
        else $error("blocking wait did not enqueue");

    // A result never both blocks and wakes
    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_blocked && r_wake_valid))
        else $error("result blocks and wakes at once");

endmodule

>>> design/counting_semaphore_fifo.sv
// A request is captured in the idle state and its result is registered from the
// execute state, which holds while the previous result is still waiting at the output.
// One request at a time: the capture/execute controller and the registered read of
// the wait queue memory keep a new request out until the previous one is committed.
// Reset: count loads 1, wait queue empty; no clearing pass, queue entries
// are undefined until written.
module counting_semaphore_fifo #(
    parameter int MAX_WAITERS = csf_pkg::DEF_MAX_WAITERS
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic                                  i_op,
    input  logic [csf_pkg::TID_W-1:0]             i_task_id,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic                                  o_blocked,
    output logic                                  o_wake_valid,
    output logic [csf_pkg::TID_W-1:0]             o_wake_task,
    output logic                                  o_refused,
    output logic signed [csf_pkg::COUNT_W-1:0]    o_count,
    input  logic                                  i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  logic [csf_pkg::INIT_W-1:0]            i_cfg_data
);
    import csf_pkg::*;

    t_cmd    cmd;
    t_status status;

    // Controller
    csf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_cfg_valid (i_cfg_valid),
        .i_status    (status),
        .o_ready     (o_ready),
        .o_cfg_ready (o_cfg_ready),
        .o_cmd       (cmd)
    );

    // Datapath
    csf_dp #(
        .MAX_WAITERS (MAX_WAITERS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_status     (status),
        .i_op         (i_op),
        .i_task_id    (i_task_id),
        .i_cfg_data   (i_cfg_data),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_blocked    (o_blocked),
        .o_wake_valid (o_wake_valid),
        .o_wake_task  (o_wake_task),
        .o_refused    (o_refused),
        .o_count      (o_count)
    );

endmodule
